// ----- rtl/assert_macros.svh -----
// assertion helpers used by dh_forward_kinematics_core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every clock edge outside reset
`define DHFK_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// implication whose consequent is checked in the cycle after the antecedent, outside reset
`define DHFK_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/dhfk_pkg.sv -----
// ----------------------------------------------------------------------------
// dhfk_pkg
// Shared types, constants and the arctangent table of the DH kinematics core.
// ----------------------------------------------------------------------------
package dhfk_pkg;

    localparam int IN_W   = 112;
    localparam int OUT_W  = 128;
    localparam int STEP_W = 5;

    localparam logic signed [16:0] ANG_PI  = 17'sd25736;
    localparam logic signed [16:0] ANG_2PI = 17'sd51472;

    localparam logic signed [33:0] HALF_PI_Q30 = 34'sd1686629713;
    localparam logic signed [33:0] PI_Q30      = 34'sd3373259426;
    localparam logic signed [33:0] GAIN_Q30    = 34'sd652032874;

    typedef logic signed [31:0] word_t;

    typedef struct packed {
        logic              load;
        logic              step;
        logic              finish;
        logic              mul;
        logic              acc;
        logic              ident;
        logic              tphase;   // 0: joint matrix products, 1: chain product
        logic [2:0]        tidx;
        logic [1:0]        r;
        logic [1:0]        c;
        logic [1:0]        k;
        logic [STEP_W-1:0] cstep;
    } dhfk_cmd_t;

    typedef struct packed {
        logic last;
    } dhfk_stat_t;

    function automatic logic signed [33:0] atan_q30(input logic [STEP_W-1:0] i);
        logic signed [33:0] v;
        unique case (i)
            5'd0:  v = 34'sh03243F6A8;
            5'd1:  v = 34'sh01DAC6705;
            5'd2:  v = 34'sh00FADBAFC;
            5'd3:  v = 34'sh007F56EA6;
            5'd4:  v = 34'sh003FEAB76;
            5'd5:  v = 34'sh001FFD55B;
            5'd6:  v = 34'sh000FFFAAA;
            5'd7:  v = 34'sh0007FFF55;
            5'd8:  v = 34'sh0003FFFEA;
            5'd9:  v = 34'sh0001FFFFD;
            5'd10: v = 34'sh0000FFFFF;
            5'd11: v = 34'sh00007FFFF;
            5'd12: v = 34'sh00003FFFF;
            5'd13: v = 34'sh00001FFFF;
            5'd14: v = 34'sh00000FFFF;
            5'd15: v = 34'sh000007FFF;
            5'd16: v = 34'sh000003FFF;
            5'd17: v = 34'sh000001FFF;
            5'd18: v = 34'sh000000FFF;
            5'd19: v = 34'sh0000007FF;
            5'd20: v = 34'sh0000003FF;
            5'd21: v = 34'sh0000001FF;
            5'd22: v = 34'sh0000000FF;
            5'd23: v = 34'sh00000007F;
            5'd24: v = 34'sh00000003F;
            5'd25: v = 34'sh00000001F;
            5'd26: v = 34'sh00000000F;
            5'd27: v = 34'sh000000007;
            5'd28: v = 34'sh000000003;
            5'd29: v = 34'sh000000001;
            default: v = 34'sd0;
        endcase
        return v;
    endfunction

    function automatic word_t sat32(input logic signed [65:0] v);
        word_t w;
        if (v > 66'sd2147483647) begin
            w = 32'sh7FFFFFFF;
        end else if (v < -66'sd2147483648) begin
            w = 32'sh80000000;
        end else begin
            w = v[31:0];
        end
        return w;
    endfunction

endpackage

// ----- rtl/dhfk_ctrl.sv -----
// ----------------------------------------------------------------------------
// dhfk_ctrl
// Sequencer: CORDIC iterations, shared multiplier schedule and row output.
// ----------------------------------------------------------------------------
module dhfk_ctrl import dhfk_pkg::*; #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic       m_tlast,
    output logic [1:0] m_tuser,
    input  dhfk_stat_t stat,
    output dhfk_cmd_t  cmd
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_CORD = 3'd1;
    localparam logic [2:0] ST_FIN  = 3'd2;
    localparam logic [2:0] ST_MUL  = 3'd3;
    localparam logic [2:0] ST_ACC  = 3'd4;
    localparam logic [2:0] ST_EMIT = 3'd5;

    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(CORDIC_STEPS - 1);

    logic [2:0]        state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              phase_reg, phase_next;
    logic [2:0]        tidx_reg, tidx_next;
    logic [1:0]        r_reg, r_next, c_reg, c_next, k_reg, k_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
            phase_reg <= 1'b0;
            tidx_reg  <= '0;
            r_reg     <= '0;
            c_reg     <= '0;
            k_reg     <= '0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
            phase_reg <= phase_next;
            tidx_reg  <= tidx_next;
            r_reg     <= r_next;
            c_reg     <= c_next;
            k_reg     <= k_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        phase_next = phase_reg;
        tidx_next  = tidx_reg;
        r_next     = r_reg;
        c_next     = c_reg;
        k_next     = k_reg;
        cmd        = '0;
        cmd.tphase = phase_reg;
        cmd.tidx   = tidx_reg;
        cmd.r      = r_reg;
        cmd.c      = c_reg;
        cmd.k      = k_reg;
        cmd.cstep  = step_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    step_next  = '0;
                    state_next = ST_CORD;
                end
            end
            ST_CORD: begin
                cmd.step = 1'b1;
                if (step_reg == LAST_STEP) begin
                    state_next = ST_FIN;
                end else begin
                    step_next = step_reg + 1'b1;
                end
            end
            ST_FIN: begin
                cmd.finish = 1'b1;
                phase_next = 1'b0;
                tidx_next  = '0;
                state_next = ST_MUL;
            end
            ST_MUL: begin
                cmd.mul    = 1'b1;
                state_next = ST_ACC;
            end
            ST_ACC: begin
                cmd.acc    = 1'b1;
                state_next = ST_MUL;
                if (!phase_reg) begin
                    if (tidx_reg == 3'd5) begin
                        phase_next = 1'b1;
                        r_next     = '0;
                        c_next     = '0;
                        k_next     = '0;
                    end else begin
                        tidx_next = tidx_reg + 1'b1;
                    end
                end else if (k_reg != 2'd2) begin
                    k_next = k_reg + 1'b1;
                end else begin
                    k_next = '0;
                    if (c_reg != 2'd3) begin
                        c_next = c_reg + 1'b1;
                    end else begin
                        c_next = '0;
                        if (r_reg != 2'd2) begin
                            r_next = r_reg + 1'b1;
                        end else begin
                            r_next     = '0;
                            state_next = stat.last ? ST_EMIT : ST_IDLE;
                        end
                    end
                end
            end
            ST_EMIT: begin
                if (m_tready) begin
                    if (r_reg == 2'd2) begin
                        cmd.ident  = 1'b1;
                        r_next     = '0;
                        state_next = ST_IDLE;
                    end else begin
                        r_next = r_reg + 1'b1;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = (state_reg == ST_EMIT);
    assign m_tlast  = (r_reg == 2'd2);
    assign m_tuser  = r_reg;

endmodule

// ----- rtl/dhfk_dp.sv -----
// ----------------------------------------------------------------------------
// dhfk_dp
// Datapath: two CORDIC lanes, one shared multiplier with rounding
// accumulator, joint matrix and running transform registers.
// ----------------------------------------------------------------------------
module dhfk_dp import dhfk_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  dhfk_cmd_t        cmd,
    input  logic [IN_W-1:0]  s_tdata,
    input  logic             s_tlast,
    output dhfk_stat_t       stat,
    output logic [OUT_W-1:0] row_data
);

    localparam int SH = 30 - FRAC_BITS;
    localparam logic signed [35:0] HALF_CS = (SH == 0) ? 36'sd0 :
                                             (36'sd1 <<< ((SH > 0) ? SH - 1 : 0));
    localparam logic signed [64:0] HALF_F  = 65'sd1 <<< (FRAC_BITS - 1);
    localparam word_t              ONE     = 32'sd1 <<< FRAC_BITS;

    word_t              d_reg, a_reg;
    logic               last_reg;
    logic signed [33:0] x_reg [2];
    logic signed [33:0] y_reg [2];
    logic signed [33:0] z_reg [2];
    logic               neg_reg [2];
    word_t              st_reg, ct_reg, sa_reg, ca_reg;
    word_t              t_reg [3][4];
    word_t              rt_reg [3][4];
    word_t              rowbuf_reg [3];
    logic signed [63:0] prod_reg;
    logic signed [65:0] acc_reg;

    // angle wrap and quadrant fold at load
    logic signed [16:0] ang_sum, ang_w [2];
    logic signed [33:0] z0 [2];
    logic signed [33:0] zf [2];
    logic               nf [2];

    always_comb begin
        ang_sum  = 17'(signed'(s_tdata[15:0])) + 17'(signed'(s_tdata[31:16]));
        ang_w[0] = ang_sum;
        ang_w[1] = 17'(signed'(s_tdata[79:64]));
        for (int l = 0; l < 2; l++) begin
            if (ang_w[l] > ANG_PI) begin
                ang_w[l] = ang_w[l] - ANG_2PI;
            end else if (ang_w[l] < -ANG_PI) begin
                ang_w[l] = ang_w[l] + ANG_2PI;
            end
            z0[l] = signed'({ang_w[l], 17'b0});
            nf[l] = 1'b1;
            if (z0[l] > HALF_PI_Q30) begin
                zf[l] = z0[l] - PI_Q30;
            end else if (z0[l] < -HALF_PI_Q30) begin
                zf[l] = z0[l] + PI_Q30;
            end else begin
                zf[l] = z0[l];
                nf[l] = 1'b0;
            end
        end
    end

    // one micro-rotation per cycle on each lane
    logic signed [33:0] xn [2];
    logic signed [33:0] yn [2];
    logic signed [33:0] zn [2];
    logic signed [33:0] at;

    always_comb begin
        at = atan_q30(cmd.cstep);
        for (int l = 0; l < 2; l++) begin
            if (!z_reg[l][33]) begin
                xn[l] = x_reg[l] - (y_reg[l] >>> cmd.cstep);
                yn[l] = y_reg[l] + (x_reg[l] >>> cmd.cstep);
                zn[l] = z_reg[l] - at;
            end else begin
                xn[l] = x_reg[l] + (y_reg[l] >>> cmd.cstep);
                yn[l] = y_reg[l] - (x_reg[l] >>> cmd.cstep);
                zn[l] = z_reg[l] + at;
            end
        end
    end

    // sign restore and rounding to the output format
    logic signed [35:0] cx [2];
    logic signed [35:0] cy [2];
    word_t              cos_w [2];
    word_t              sin_w [2];

    always_comb begin
        for (int l = 0; l < 2; l++) begin
            cx[l] = neg_reg[l] ? -36'(x_reg[l]) : 36'(x_reg[l]);
            cy[l] = neg_reg[l] ? -36'(y_reg[l]) : 36'(y_reg[l]);
            cx[l] = (cx[l] + HALF_CS) >>> SH;
            cy[l] = (cy[l] + HALF_CS) >>> SH;
            cos_w[l] = sat32(66'(cx[l]));
            sin_w[l] = sat32(66'(cy[l]));
        end
    end

    // multiplier operands
    word_t opa, opb;

    always_comb begin
        if (cmd.tphase) begin
            opa = rt_reg[cmd.r][cmd.k];
            opb = t_reg[cmd.k][cmd.c];
        end else begin
            unique case (cmd.tidx)
                3'd0:    begin opa = st_reg; opb = ca_reg; end
                3'd1:    begin opa = st_reg; opb = sa_reg; end
                3'd2:    begin opa = a_reg;  opb = ct_reg; end
                3'd3:    begin opa = ct_reg; opb = ca_reg; end
                3'd4:    begin opa = ct_reg; opb = sa_reg; end
                default: begin opa = a_reg;  opb = st_reg; end
            endcase
        end
    end

    logic signed [64:0] rnd;
    logic signed [65:0] tval, base, sum;
    word_t              sum_sat;

    always_comb begin
        rnd  = (65'(prod_reg) + HALF_F) >>> FRAC_BITS;
        tval = (cmd.tidx == 3'd0 || cmd.tidx == 3'd4) ? -66'(rnd) : 66'(rnd);
        if (cmd.k != 2'd0) begin
            base = acc_reg;
        end else if (cmd.c == 2'd3) begin
            base = 66'(rt_reg[cmd.r][3]);
        end else begin
            base = '0;
        end
        sum     = base + 66'(rnd);
        sum_sat = sat32(sum);
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            d_reg    <= s_tdata[63:32];
            a_reg    <= s_tdata[111:80];
            last_reg <= s_tlast;
            for (int l = 0; l < 2; l++) begin
                x_reg[l]   <= GAIN_Q30;
                y_reg[l]   <= '0;
                z_reg[l]   <= zf[l];
                neg_reg[l] <= nf[l];
            end
        end
        if (cmd.step) begin
            for (int l = 0; l < 2; l++) begin
                x_reg[l] <= xn[l];
                y_reg[l] <= yn[l];
                z_reg[l] <= zn[l];
            end
        end
        if (cmd.finish) begin
            ct_reg     <= cos_w[0];
            st_reg     <= sin_w[0];
            ca_reg     <= cos_w[1];
            sa_reg     <= sin_w[1];
            t_reg[0][0] <= cos_w[0];
            t_reg[1][0] <= sin_w[0];
            t_reg[2][0] <= '0;
            t_reg[2][1] <= sin_w[1];
            t_reg[2][2] <= cos_w[1];
            t_reg[2][3] <= d_reg;
        end
        if (cmd.mul) begin
            prod_reg <= 64'(opa) * 64'(opb);
        end
        if (cmd.acc) begin
            if (!cmd.tphase) begin
                unique case (cmd.tidx)
                    3'd0:    t_reg[0][1] <= sat32(tval);
                    3'd1:    t_reg[0][2] <= sat32(tval);
                    3'd2:    t_reg[0][3] <= sat32(tval);
                    3'd3:    t_reg[1][1] <= sat32(tval);
                    3'd4:    t_reg[1][2] <= sat32(tval);
                    default: t_reg[1][3] <= sat32(tval);
                endcase
            end else begin
                acc_reg <= sum;
                if (cmd.k == 2'd2 && cmd.c != 2'd3) begin
                    rowbuf_reg[cmd.c] <= sum_sat;
                end
            end
        end
    end

    // running transform: whole row written once its last column is done
    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.ident) begin
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 4; c++) begin
                    rt_reg[r][c] <= (r == c) ? ONE : '0;
                end
            end
        end else if (cmd.acc && cmd.tphase && cmd.k == 2'd2 && cmd.c == 2'd3) begin
            rt_reg[cmd.r][0] <= rowbuf_reg[0];
            rt_reg[cmd.r][1] <= rowbuf_reg[1];
            rt_reg[cmd.r][2] <= rowbuf_reg[2];
            rt_reg[cmd.r][3] <= sum_sat;
        end
    end

    assign stat.last = last_reg;
    assign row_data  = {rt_reg[cmd.r][3], rt_reg[cmd.r][2], rt_reg[cmd.r][1],
                        rt_reg[cmd.r][0]};

endmodule

// ----- rtl/dh_forward_kinematics_core.sv -----
// ----------------------------------------------------------------------------
// dh_forward_kinematics_core
// Denavit-Hartenberg chain: one joint per request, pose rows on the last joint.
// ----------------------------------------------------------------------------
// One joint is taken at a time. After a joint is accepted the core runs
// CORDIC_STEPS CORDIC micro-rotations (theta and alpha lanes side by side),
// a rounding step, then 42 products through a single 32x32 multiplier, each
// a multiply state then an accumulate state (6 for the joint matrix, 36 for
// the chain product); no new joint is accepted before the last product.
// On a joint with s_tlast set the three pose rows follow on the m_ side,
// one per request, and the running transform then returns to identity.
`include "assert_macros.svh"

module dh_forward_kinematics_core import dhfk_pkg::*; #(
    parameter int CORDIC_STEPS = 16,
    parameter int FRAC_BITS    = 16
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    // theta_offset, joint_angle, link_offset_d, link_twist_alpha, link_length_a
    input  logic [IN_W-1:0]  s_tdata,
    input  logic             s_tlast,
    output logic             m_tvalid,
    input  logic             m_tready,
    // col_0, col_1, col_2, col_3
    output logic [OUT_W-1:0] m_tdata,
    // row_index
    output logic [1:0]       m_tuser,
    output logic             m_tlast
);

    dhfk_cmd_t  cmd;
    dhfk_stat_t stat;

    dhfk_ctrl #(
        .CORDIC_STEPS(CORDIC_STEPS)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser),
        .stat     (stat),
        .cmd      (cmd)
    );

    dhfk_dp #(
        .FRAC_BITS(FRAC_BITS)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .stat     (stat),
        .row_data (m_tdata)
    );

    `DHFK_ASSERT(a_no_overlap, !(m_tvalid && s_tready), "input taken while rows pending")
    `DHFK_ASSERT(a_row_range, !m_tvalid || m_tuser != 2'd3, "row index out of range")
    `DHFK_ASSERT_NEXT(a_busy_after_req, s_tvalid && s_tready, !s_tready, "no busy after request")
    `DHFK_ASSERT_NEXT(a_done_after_last, m_tvalid && m_tready && m_tlast, !m_tvalid,
        "rows continue after last")

endmodule
